FILE: rtl/core/mi4_pkg.sv
package mi4_pkg;

    localparam logic [3:0] LastIndex  = 4'd15;
    localparam int         QueueDepth = 4;
    localparam int         QuoBits    = 32;
    localparam int         QuoCntW    = $clog2(QuoBits);
    localparam logic [31:0] SatMax    = 32'h7FFF_FFFF;
    localparam logic [31:0] SatMin    = 32'h8000_0000;
    localparam logic [2:0] LastPerm   = 3'd5;
    localparam logic [1:0] LastDetCol = 2'd3;

    typedef enum logic [4:0] {
        S_LOAD,
        S_FX,
        S_FY,
        S_FZ,
        S_GZ,
        S_MUL1,
        S_SET2,
        S_MUL2,
        S_ACC,
        S_DF,
        S_DG,
        S_DMUL,
        S_DACC,
        S_DCHK,
        S_QF,
        S_QG,
        S_QDIV,
        S_QSAT,
        S_OUT
    } mi4_state_t;

    // column picked by each row of a 3x3 permutation term, packed {row2, row1, row0}
    function automatic logic [5:0] mi4_perm_cols(input logic [2:0] perm);
        logic [5:0] cols;
        unique case (perm)
            3'd0:    cols = {2'd2, 2'd1, 2'd0};
            3'd1:    cols = {2'd0, 2'd2, 2'd1};
            3'd2:    cols = {2'd1, 2'd0, 2'd2};
            3'd3:    cols = {2'd1, 2'd2, 2'd0};
            3'd4:    cols = {2'd0, 2'd1, 2'd2};
            3'd5:    cols = {2'd2, 2'd0, 2'd1};
            default: cols = {2'd2, 2'd1, 2'd0};
        endcase
        return cols;
    endfunction

    function automatic logic mi4_perm_odd(input logic [2:0] perm);
        return perm >= 3'd3;
    endfunction

    // store address of factor j of term perm in the minor of cofactor k
    function automatic logic [3:0] mi4_term_addr(input logic [3:0] k, input logic [2:0] perm,
                                                 input logic [1:0] j);
        logic [1:0] sr;
        logic [1:0] sc;
        logic [1:0] r;
        logic [1:0] pc;
        logic [1:0] c;
        logic [5:0] cols;
        sr   = k[3:2];
        sc   = k[1:0];
        cols = mi4_perm_cols(perm);
        r    = j + {1'b0, j >= sr};
        pc   = cols[2*j +: 2];
        c    = pc + {1'b0, pc >= sc};
        return {c, r};
    endfunction

endpackage

FILE: rtl/core/matrix_inverse_4x4_top.sv
// 4x4 matrix inverse, signed Q16.16, exact cofactor method.
// Input channel (in_valid/in_ready, element_value): sixteen words per matrix,
// column-major. Output channel (out_valid/out_ready): sixteen words per matrix,
// column-major, with element_index, last_element on the sixteenth and singular
// when the determinant is zero (values are then zero).
// Input words enter a four-word queue; the engine drains it into its element
// store one word per cycle while it is in its loading state.
// After the sixteenth word the engine forms the sixteen cofactors from 96
// triple products on one shared 8-bit-digit multiply-add unit, then the
// determinant in 4 more products. Each result then takes one restoring
// divider pass of 32 steps; singular or saturated results skip the divider.
// While the engine works, up to four words of the next matrix are accepted.
// A stalled receiver holds the engine in its output register; nothing is lost.
// Reset clears the word counter, queue and engine state; the store is not
// cleared, as every entry is written before use.
module matrix_inverse_4x4_top
    import mi4_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ELEMENT_WIDTH-1:0] element_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [31:0]              inverse_value,
    output logic [3:0]               element_index,
    output logic                     last_element,
    output logic                     singular
);

    localparam int QW = ELEMENT_WIDTH + 4;

    logic                     push_valid;
    logic                     push_ready;
    logic [ELEMENT_WIDTH-1:0] push_value;
    logic [3:0]               push_index;
    logic                     q_valid;
    logic                     q_ready;
    logic [QW-1:0]            q_data;

    mi4_front #(
        .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_value    (push_value),
        .push_index    (push_index)
    );

    mi4_fifo #(
        .WIDTH(QW)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_index, push_value}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    mi4_engine #(
        .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_value       (q_data[ELEMENT_WIDTH-1:0]),
        .q_index       (q_data[QW-1:ELEMENT_WIDTH]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .inverse_value (inverse_value),
        .element_index (element_index),
        .last_element  (last_element),
        .singular      (singular)
    );

endmodule

FILE: rtl/core/mi4_front.sv
module mi4_front
    import mi4_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ELEMENT_WIDTH-1:0] element_value,
    output logic                     push_valid,
    input  logic                     push_ready,
    output logic [ELEMENT_WIDTH-1:0] push_value,
    output logic [3:0]               push_index
);

    logic [3:0] load_count_reg;
    logic [3:0] load_count_next;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push_value = element_value;
    assign push_index = load_count_reg;

    always_comb
    begin
        load_count_next = load_count_reg;
        if (in_valid && push_ready)
        begin
            load_count_next = (load_count_reg == LastIndex) ? 4'd0 : load_count_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= 4'd0;
        end
        else
        begin
            load_count_reg <= load_count_next;
        end
    end

endmodule

FILE: rtl/core/mi4_fifo.sv
module mi4_fifo
    import mi4_pkg::*;
#(
    parameter int WIDTH = 36
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PtrW = $clog2(QueueDepth);

    logic [WIDTH-1:0]  slot_reg [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [PtrW:0]     count_reg;
    logic [PtrW:0]     count_next;
    logic              push;
    logic              pop;

    assign wr_ready = count_reg != (PtrW+1)'(QueueDepth);
    assign rd_valid = count_reg != '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/mi4_engine.sv
module mi4_engine
    import mi4_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  logic [ELEMENT_WIDTH-1:0] q_value,
    input  logic [3:0]               q_index,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [31:0]              inverse_value,
    output logic [3:0]               element_index,
    output logic                     last_element,
    output logic                     singular
);

    localparam int EW   = ELEMENT_WIDTH;
    localparam int DIG  = 8;
    localparam int NDIG = (EW + DIG - 1) / DIG;
    localparam int DCW  = $clog2(NDIG);
    localparam int AW   = 4 * EW + 8;

    function automatic logic [EW-1:0] ew_abs(input logic [EW-1:0] v);
        return v[EW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [AW-1:0] aw_abs(input logic [AW-1:0] v);
        return v[AW-1] ? (~v + 1'b1) : v;
    endfunction

    mi4_state_t          state_reg, state_next;
    logic [3:0]          k_reg, k_next;
    logic [2:0]          perm_reg, perm_next;
    logic [DCW-1:0]      dcnt_reg, dcnt_next;
    logic [QuoCntW-1:0]  qcnt_reg, qcnt_next;
    logic                out_valid_reg, out_valid_next;

    logic [AW-1:0]       mcand_reg, mcand_next;
    logic [EW-1:0]       mplier_reg, mplier_next;
    logic [EW-1:0]       zmag_reg, zmag_next;
    logic [AW-1:0]       prod_reg, prod_next;
    logic [AW-1:0]       acc_reg, acc_next;
    logic                sgn_reg, sgn_next;
    logic [AW-1:0]       dmag_reg, dmag_next;
    logic                dneg_reg, dneg_next;
    logic                sing_reg, sing_next;
    logic [AW-1:0]       rem_reg, rem_next;
    logic [QuoBits-1:0]  quo_reg, quo_next;
    logic                qneg_reg, qneg_next;
    logic [31:0]         value_reg, value_next;
    logic                last_reg, last_next;
    logic [3:0]          idx_reg, idx_next;

    logic [EW-1:0]       elem_mem [16];
    logic [EW-1:0]       elem_rd_reg;
    logic [3:0]          elem_rd_addr;
    logic                elem_we;
    logic [AW-1:0]       cof_mem [16];
    logic [AW-1:0]       cof_rd_reg;
    logic                cof_we;
    logic [AW-1:0]       cof_wdata;

    logic [AW-1:0]       mul_sum;
    logic [AW-1:0]       acc_sum;
    logic [AW:0]         rem2;
    logic [EW-1:0]       emag;
    logic                esgn;
    logic [AW-1:0]       nmag;
    logic                dig_last;

    assign mul_sum  = prod_reg + mcand_reg * {{(AW-DIG){1'b0}}, mplier_reg[DIG-1:0]};
    assign acc_sum  = sgn_reg ? acc_reg - prod_reg : acc_reg + prod_reg;
    assign rem2     = {rem_reg, 1'b0};
    assign emag     = ew_abs(elem_rd_reg);
    assign esgn     = elem_rd_reg[EW-1];
    assign nmag     = aw_abs(cof_rd_reg);
    assign dig_last = dcnt_reg == DCW'(NDIG - 1);

    assign q_ready       = state_reg == S_LOAD;
    assign out_valid     = out_valid_reg;
    assign inverse_value = value_reg;
    assign element_index = idx_reg;
    assign last_element  = last_reg;
    assign singular      = sing_reg;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        perm_next      = perm_reg;
        dcnt_next      = dcnt_reg;
        qcnt_next      = qcnt_reg;
        out_valid_next = out_valid_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        zmag_next      = zmag_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        sgn_next       = sgn_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        sing_next      = sing_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        qneg_next      = qneg_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        elem_we        = 1'b0;
        elem_rd_addr   = 4'd0;
        cof_we         = 1'b0;
        cof_wdata      = acc_sum;

        unique case (state_reg)
            S_LOAD:
            begin
                if (q_valid)
                begin
                    elem_we = 1'b1;
                    if (q_index == LastIndex)
                    begin
                        k_next     = 4'd0;
                        perm_next  = 3'd0;
                        acc_next   = '0;
                        state_next = S_FX;
                    end
                end
            end
            S_FX:
            begin
                elem_rd_addr = mi4_term_addr(k_reg, perm_reg, 2'd0);
                state_next   = S_FY;
            end
            S_FY:
            begin
                elem_rd_addr = mi4_term_addr(k_reg, perm_reg, 2'd1);
                mcand_next   = AW'(emag);
                sgn_next     = esgn ^ mi4_perm_odd(perm_reg) ^ k_reg[2] ^ k_reg[0];
                state_next   = S_FZ;
            end
            S_FZ:
            begin
                elem_rd_addr = mi4_term_addr(k_reg, perm_reg, 2'd2);
                mplier_next  = emag;
                sgn_next     = sgn_reg ^ esgn;
                state_next   = S_GZ;
            end
            S_GZ:
            begin
                zmag_next  = emag;
                sgn_next   = sgn_reg ^ esgn;
                prod_next  = '0;
                dcnt_next  = '0;
                state_next = S_MUL1;
            end
            S_MUL1, S_MUL2, S_DMUL:
            begin
                prod_next   = mul_sum;
                mcand_next  = mcand_reg << DIG;
                mplier_next = mplier_reg >> DIG;
                dcnt_next   = dcnt_reg + 1'b1;
                if (dig_last)
                begin
                    unique case (state_reg)
                        S_MUL1:  state_next = S_SET2;
                        S_MUL2:  state_next = S_ACC;
                        default: state_next = S_DACC;
                    endcase
                end
            end
            S_SET2:
            begin
                mcand_next  = prod_reg;
                mplier_next = zmag_reg;
                prod_next   = '0;
                dcnt_next   = '0;
                state_next  = S_MUL2;
            end
            S_ACC:
            begin
                if (perm_reg == LastPerm)
                begin
                    cof_we    = 1'b1;
                    acc_next  = '0;
                    perm_next = 3'd0;
                    if (k_reg == LastIndex)
                    begin
                        k_next     = 4'd0;
                        state_next = S_DF;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        state_next = S_FX;
                    end
                end
                else
                begin
                    acc_next   = acc_sum;
                    perm_next  = perm_reg + 3'd1;
                    state_next = S_FX;
                end
            end
            S_DF:
            begin
                elem_rd_addr = {k_reg[1:0], 2'b00};
                state_next   = S_DG;
            end
            S_DG:
            begin
                mplier_next = emag;
                mcand_next  = nmag;
                sgn_next    = esgn ^ cof_rd_reg[AW-1];
                prod_next   = '0;
                dcnt_next   = '0;
                state_next  = S_DMUL;
            end
            S_DACC:
            begin
                acc_next = acc_sum;
                if (k_reg[1:0] == LastDetCol)
                begin
                    k_next     = 4'd0;
                    state_next = S_DCHK;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_DF;
                end
            end
            S_DCHK:
            begin
                dmag_next  = aw_abs(acc_reg);
                dneg_next  = acc_reg[AW-1];
                sing_next  = acc_reg == '0;
                state_next = S_QF;
            end
            S_QF:
            begin
                state_next = S_QG;
            end
            S_QG:
            begin
                qneg_next = cof_rd_reg[AW-1] ^ dneg_reg;
                idx_next  = k_reg;
                last_next = k_reg == LastIndex;
                priority if (sing_reg)
                begin
                    value_next     = 32'd0;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else if (nmag >= dmag_reg)
                begin
                    value_next     = (cof_rd_reg[AW-1] ^ dneg_reg) ? SatMin : SatMax;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    rem_next   = nmag;
                    quo_next   = '0;
                    qcnt_next  = '0;
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                if (rem2 >= {1'b0, dmag_reg})
                begin
                    rem_next = AW'(rem2 - {1'b0, dmag_reg});
                    quo_next = {quo_reg[QuoBits-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[AW-1:0];
                    quo_next = {quo_reg[QuoBits-2:0], 1'b0};
                end
                qcnt_next = qcnt_reg + 1'b1;
                if (qcnt_reg == QuoCntW'(QuoBits - 1))
                begin
                    state_next = S_QSAT;
                end
            end
            S_QSAT:
            begin
                if (qneg_reg)
                begin
                    value_next = quo_reg[QuoBits-1] ? SatMin : (32'd0 - quo_reg);
                end
                else
                begin
                    value_next = quo_reg[QuoBits-1] ? SatMax : quo_reg;
                end
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (k_reg == LastIndex)
                    begin
                        k_next     = 4'd0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        state_next = S_QF;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            k_reg         <= 4'd0;
            perm_reg      <= 3'd0;
            dcnt_reg      <= '0;
            qcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            perm_reg      <= perm_next;
            dcnt_reg      <= dcnt_next;
            qcnt_reg      <= qcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        zmag_reg   <= zmag_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        sgn_reg    <= sgn_next;
        dmag_reg   <= dmag_next;
        dneg_reg   <= dneg_next;
        sing_reg   <= sing_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        qneg_reg   <= qneg_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[q_index] <= q_value;
        end
        elem_rd_reg <= elem_mem[elem_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cof_we)
        begin
            cof_mem[k_reg] <= cof_wdata;
        end
        cof_rd_reg <= cof_mem[k_reg];
    end

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_OUT)
        else $error("result word shown outside output state");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && last_reg) |=> state_reg == S_LOAD)
        else $error("engine did not return to loading after last word");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sing_reg) |-> value_reg == 32'd0)
        else $error("singular result carries nonzero value");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_QDIV |-> rem_reg < dmag_reg)
        else $error("division remainder out of range");

endmodule
